// ----- sv/configurable_calendar_clock_assert.svh -----
// assertion helpers for the calendar clock
`ifndef CONFIGURABLE_CALENDAR_CLOCK_ASSERT_SVH
`define CONFIGURABLE_CALENDAR_CLOCK_ASSERT_SVH

// implication checked on every edge outside reset
`define CCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// implication checked on the following edge
`define CCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

// ----- sv/ccc_pkg.sv -----
`timescale 1ns / 1ps
package ccc_pkg;
  localparam int unsigned MIN_PER_DAY = 1440;
  localparam logic [30:0] YEAR_LIMIT  = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_DATE = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_YEAR_LIM = 3'd3,
    ST_ZERO_LEN = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    CMD_SET     = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MONTH_COUNT = 2'd0,
    REG_LEN_LOW     = 2'd1,
    REG_LEN_HIGH    = 2'd2
  } reg_idx_t;
endpackage

// ----- sv/configurable_calendar_clock.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in      | to block  | in_valid/in_stall  | cmd, set_year, set_month, set_day,
//         |           |                    | set_minute, advance_amount
// out     | from block| out_valid/out_stall| status, year, month, day,
//         |           |                    | day_minute, total_minutes
// cfg     | to block  | apb psel/penable   | month_count, month_lengths_*
//
// one command at a time; its result beat appears after the sequencer ends
// a set raises out_valid once the month walk, the multiplier and the minute sum are done
// an advance runs two 63-bit restoring divisions, one bit a cycle, then walks the months
// a set passes year - 1 through the shift-add multiplier, one year bit a cycle
// synchronous reset returns the clock to year one, month one, day one, minute 0
// in_stall is high while a command is in flight or its result beat is unclaimed
module configurable_calendar_clock #(
  parameter int MAX_MONTHS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [30:0] set_year,
  input  logic [4:0]  set_month,
  input  logic [7:0]  set_day,
  input  logic [10:0] set_minute,
  input  logic [62:0] advance_amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [30:0] year,
  output logic [4:0]  month,
  output logic [7:0]  day,
  output logic [10:0] day_minute,
  output logic [62:0] total_minutes,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_YLEN, S_CHECK, S_SMUL, S_SADD, S_ADD, S_DIV1, S_DIV2,
    S_YCHK, S_WALK, S_DONE, S_OUT
  } state_t;

  // configuration registers
  logic [4:0]  month_count;
  logic [63:0] len_low, len_high;
  logic [1:0]  reg_sel;
  assign reg_sel = paddr[4:3];
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_sel)
      ccc_pkg::REG_MONTH_COUNT: prdata = {59'd0, month_count};
      ccc_pkg::REG_LEN_LOW:     prdata = len_low;
      ccc_pkg::REG_LEN_HIGH:    prdata = len_high;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      month_count <= 5'd12;
      len_low     <= 64'd2242544258451971103;
      len_high    <= 64'd522067742;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        ccc_pkg::REG_MONTH_COUNT: month_count <= pwdata[4:0];
        ccc_pkg::REG_LEN_LOW:     len_low     <= pwdata;
        ccc_pkg::REG_LEN_HIGH:    len_high    <= pwdata;
        default: ;
      endcase
    end
  end

  // months in use, clamped to the parameter
  logic [4:0] months_used;
  assign months_used = (month_count > 5'(MAX_MONTHS)) ? 5'(MAX_MONTHS) : month_count;

  // length of one month, index chosen by a small counter
  function automatic logic [7:0] mlen(input logic [63:0] lo, input logic [63:0] hi,
                                      input logic [3:0] idx);
    logic [63:0] w;
    w = idx[3] ? hi : lo;
    return w[idx[2:0]*8 +: 8];
  endfunction

  // state of the clock
  state_t      state;
  logic [62:0] minute_total;
  logic [30:0] cur_year;
  logic [4:0]  cur_month;
  logic [7:0]  cur_day;
  logic [10:0] cur_minute;

  // captured command
  logic        c_cmd;
  logic [30:0] c_year;
  logic [4:0]  c_month;
  logic [7:0]  c_day;
  logic [10:0] c_min;
  logic [62:0] c_amt;

  // working registers
  logic [4:0]  idx;          // month counter, holds up to MAX_MONTHS
  logic [11:0] ydays;        // days per year (16 * 255 fits)
  logic        zero_len;
  logic [11:0] pre_days;     // days before the set month
  logic [63:0] acc;          // multiplier accumulator / walk remainder
  logic [30:0] mcand_cnt;    // multiplier shift register (year - 1)
  logic [5:0]  bit_cnt;
  logic [62:0] dvd;          // dividend / quotient shift register
  logic [11:0] rmd;          // partial remainder
  logic [11:0] divisor;
  logic [62:0] next_total;
  logic [10:0] r_minute;
  logic [2:0]  r_status;
  logic        pass2;

  logic [7:0]  len_cur;
  assign len_cur = mlen(len_low, len_high, idx[3:0]);

  logic [12:0] trial;
  assign trial = {rmd, dvd[62]} ;

  logic        bad_date;
  assign bad_date = (c_year == 31'd0) || (c_month == 5'd0) || (c_month > months_used) ||
                    (c_day == 8'd0) || (c_day > mlen(len_low, len_high, 4'(c_month - 5'd1))) ||
                    (c_min >= 11'(ccc_pkg::MIN_PER_DAY));

  logic [63:0] sum64;
  assign sum64 = {1'b0, minute_total} + {1'b0, c_amt};

  assign in_stall = (state != S_IDLE);

  localparam logic [62:0] YEAR_LIMIT_W = 63'(ccc_pkg::YEAR_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      minute_total <= '0;
      cur_year     <= 31'd1;
      cur_month    <= 5'd1;
      cur_day      <= 8'd1;
      cur_minute   <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          c_cmd   <= cmd;
          c_year  <= set_year;
          c_month <= set_month;
          c_day   <= set_day;
          c_min   <= set_minute;
          c_amt   <= advance_amount;
          idx     <= '0;
          ydays   <= '0;
          pre_days <= '0;
          zero_len <= (months_used == 5'd0);
          state   <= S_YLEN;
        end
        // walk the months: year length, zero check, days before set month
        S_YLEN: begin
          if (idx == months_used) begin
            state <= S_CHECK;
          end else begin
            if (len_cur == 8'd0) zero_len <= 1'b1;
            ydays <= ydays + 12'(len_cur);
            if (idx + 5'd1 < c_month) pre_days <= pre_days + 12'(len_cur);
            idx <= idx + 5'd1;
          end
        end
        S_CHECK: begin
          if (zero_len) begin
            r_status <= ccc_pkg::ST_ZERO_LEN;
            state    <= S_OUT;
          end else if (c_cmd == ccc_pkg::CMD_SET) begin
            if (bad_date) begin
              r_status <= ccc_pkg::ST_BAD_DATE;
              state    <= S_OUT;
            end else begin
              acc       <= '0;
              mcand_cnt <= c_year - 31'd1;
              bit_cnt   <= '0;
              state     <= S_SMUL;
            end
          end else begin
            state <= S_ADD;
          end
        end
        // (year-1)*ydays, one multiplier bit per cycle from the top
        S_SMUL: begin
          acc       <= (acc << 1) + (mcand_cnt[30] ? 64'(ydays) : 64'd0);
          mcand_cnt <= mcand_cnt << 1;
          if (bit_cnt == 6'd30) begin
            bit_cnt <= '0;
            state   <= S_SADD;
          end else begin
            bit_cnt <= bit_cnt + 6'd1;
          end
        end
        // days*1440 + minute, 1440 taken as a sum of four shifts
        S_SADD: begin
          if (bit_cnt == 6'd0) begin
            acc     <= acc + 64'(pre_days) + 64'(c_day) - 64'd1;
            bit_cnt <= 6'd1;
          end else begin
            minute_total <= 63'((acc << 10) + (acc << 8) + (acc << 7) + (acc << 5)
                            + 64'(c_min));
            cur_year   <= c_year;
            cur_month  <= c_month;
            cur_day    <= c_day;
            cur_minute <= c_min;
            r_status   <= ccc_pkg::ST_OK;
            state      <= S_OUT;
          end
        end
        S_ADD: begin
          if (sum64[63]) begin
            r_status <= ccc_pkg::ST_OVERFLOW;
            state    <= S_OUT;
          end else begin
            next_total <= sum64[62:0];
            dvd        <= sum64[62:0];
            rmd        <= '0;
            divisor    <= 12'(ccc_pkg::MIN_PER_DAY);
            bit_cnt    <= '0;
            pass2      <= 1'b0;
            state      <= S_DIV1;
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIV1: begin
          if (trial >= {1'b0, divisor}) rmd <= 12'(trial - {1'b0, divisor});
          else                          rmd <= trial[11:0];
          dvd     <= {dvd[61:0], trial >= {1'b0, divisor}};
          bit_cnt <= bit_cnt + 6'd1;
          if (bit_cnt == 6'd62) state <= S_DIV2;
        end
        S_DIV2: begin
          if (!pass2) begin
            r_minute <= rmd[10:0];
            rmd      <= '0;
            divisor  <= ydays;
            bit_cnt  <= '0;
            pass2    <= 1'b1;
            state    <= S_DIV1;
          end else begin
            state <= S_YCHK;
          end
        end
        S_YCHK: begin
          if (dvd >= YEAR_LIMIT_W) begin
            r_status <= ccc_pkg::ST_YEAR_LIM;
            state    <= S_OUT;
          end else begin
            acc   <= 64'(rmd);
            idx   <= '0;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (idx < months_used && acc[11:0] >= 12'(len_cur)) begin
            acc <= acc - 64'(len_cur);
            idx <= idx + 5'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          minute_total <= next_total;
          cur_minute   <= r_minute;
          cur_year     <= dvd[30:0] + 31'd1;
          cur_month    <= idx + 5'd1;
          cur_day      <= acc[7:0] + 8'd1;
          r_status     <= ccc_pkg::ST_OK;
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status        = r_status;
  assign year          = cur_year;
  assign month         = cur_month;
  assign day           = cur_day;
  assign day_minute    = cur_minute;
  assign total_minutes = minute_total;

`include "configurable_calendar_clock_assert.svh"
  `CCC_ASSERT_IMP(a_out_only_in_out, out_valid, state == S_OUT)
  `CCC_ASSERT_IMP(a_minute_range, out_valid, cur_minute < 11'(ccc_pkg::MIN_PER_DAY))
  `CCC_ASSERT_NEXT(a_beat_done, out_valid && !out_stall, !out_valid && state == S_IDLE)

endmodule
